// ===== rtl/swps_pkg.sv =====
// package: shared types, codes and helpers of the weighted port selector
package swps_pkg;

	localparam logic [2:0] CMD_SEND     = 3'd0;
	localparam logic [2:0] CMD_ATTACH   = 3'd1;
	localparam logic [2:0] CMD_DETACH   = 3'd2;
	localparam logic [2:0] CMD_WEIGHT   = 3'd3;
	localparam logic [2:0] CMD_WRITABLE = 3'd4;
	localparam logic [2:0] CMD_ROLLBACK = 3'd5;

	localparam logic [2:0] ST_SENT      = 3'd0;
	localparam logic [2:0] ST_DROPPED   = 3'd1;
	localparam logic [2:0] ST_AGAIN     = 3'd2;
	localparam logic [2:0] ST_REFUSED   = 3'd3;
	localparam logic [2:0] ST_TOO_LARGE = 3'd4;
	localparam logic [2:0] ST_ABORTED   = 3'd5;
	localparam logic [2:0] ST_DONE      = 3'd6;

	localparam int MASK_W = 8;
	localparam int RV_W   = 16;
	localparam int ACC_W  = 20;

	typedef struct packed {
		logic [2:0] cmd;
		logic [2:0] port;
		logic [9:0] weight;
		logic       frame_more;
		logic [7:0] ready_mask;
		logic [7:0] full_mask;
		logic       too_large;
	} in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] sel_port;
		logic       hwm_blocked;
	} out_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic sel_step;
	} ctl_t;

	typedef struct packed {
		logic need_sel;
		logic sel_done;
	} stat_t;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_DECODE = 4'b0010,
		S_SELECT = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	function automatic logic [RV_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
		logic [RV_W-1:0] r;
		if (v > $signed(ACC_W'(32767)))
			r = 16'h7fff;
		else if (v < -$signed(ACC_W'(32768)))
			r = 16'h8000;
		else
			r = v[RV_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/swps_ctrl.sv =====
// controller: sequences decode, selection retries and the result beat
module swps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  swps_pkg::stat_t   stat,
	output swps_pkg::ctl_t    ctl,
	output logic              busy,
	output logic              done
);

	swps_pkg::state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		case (state_q)
			swps_pkg::S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d = swps_pkg::S_DECODE;
				end
			end
			swps_pkg::S_DECODE: begin
				if (stat.need_sel) begin
					state_d = swps_pkg::S_SELECT;
				end else begin
					ctl.exec = 1'b1;
					state_d = swps_pkg::S_RESULT;
				end
			end
			swps_pkg::S_SELECT: begin
				ctl.sel_step = 1'b1;
				if (stat.sel_done)
					state_d = swps_pkg::S_RESULT;
			end
			swps_pkg::S_RESULT: state_d = swps_pkg::S_IDLE;
			default: state_d = swps_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= swps_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != swps_pkg::S_IDLE);
	assign done = (state_q == swps_pkg::S_RESULT);

endmodule

// ===== rtl/swps_dp.sv =====
// datapath: port table, message state, selection and result register
module swps_dp #(
	parameter int NUM_PORTS      = 8,
	parameter int MAX_WEIGHT     = 1023,
	parameter int DEFAULT_WEIGHT = 100
) (
	input  logic             clk,
	input  logic             arst_n,
	input  swps_pkg::in_t    item,
	input  swps_pkg::ctl_t   ctl,
	output swps_pkg::stat_t  stat,
	output swps_pkg::out_t   result
);

	localparam int AW = swps_pkg::ACC_W;
	localparam int RW = swps_pkg::RV_W;

	swps_pkg::in_t  in_q;
	swps_pkg::out_t res_q, res_d;

	logic [9:0]    weight_q [NUM_PORTS];
	logic [RW-1:0] rv_q     [NUM_PORTS];
	logic [NUM_PORTS-1:0] att_q, act_q;
	logic in_msg_q, drop_q, mpv_q;
	logic [2:0] mport_q;

	logic [9:0]    weight_d [NUM_PORTS];
	logic [RW-1:0] rv_d     [NUM_PORTS];
	logic [NUM_PORTS-1:0] att_d, act_d;
	logic in_msg_d, drop_d, mpv_d;
	logic [2:0] mport_d;

	logic [NUM_PORTS-1:0] cand, rdy, full;
	logic found, best_rdy, hwm, positive, sticky, hold_p, port_ok, mp_ok;
	logic [2:0] best;
	logic signed [AW-1:0] bval, v, added;
	logic [AW-1:0] total;
	logic [9:0] wsat;
	logic [RW-1:0] sat_a;

	always_comb begin
		for (int i = 0; i < NUM_PORTS; i++) begin
			if (i < swps_pkg::MASK_W) begin
				rdy[i]  = in_q.ready_mask[i];
				full[i] = in_q.full_mask[i];
			end else begin
				rdy[i]  = 1'b0;
				full[i] = 1'b0;
			end
			cand[i] = att_q[i] & act_q[i] & (weight_q[i] != '0);
		end
	end

	// running max over candidates, lowest index wins ties
	always_comb begin
		found = 1'b0;
		best = '0;
		bval = '0;
		total = '0;
		best_rdy = 1'b0;
		hwm = 1'b0;
		positive = 1'b0;
		for (int i = 0; i < NUM_PORTS; i++) begin
			v = $signed({{(AW-RW){rv_q[i][RW-1]}}, rv_q[i]}) + $signed(AW'(weight_q[i]));
			if (cand[i]) begin
				total = total + AW'(weight_q[i]);
				if (!found || v > bval) begin
					found = 1'b1;
					best = 3'(i);
					bval = v;
					best_rdy = rdy[i];
				end
			end
			if (att_q[i] && weight_q[i] != '0) begin
				positive = 1'b1;
				if (full[i])
					hwm = 1'b1;
			end
		end
	end

	assign sticky = in_msg_q & mpv_q;
	assign stat.need_sel = (in_q.cmd == swps_pkg::CMD_SEND) & ~drop_q & ~sticky;
	assign stat.sel_done = ~found | in_q.too_large | best_rdy;
	assign port_ok = (int'(in_q.port) < NUM_PORTS);
	assign mp_ok = (int'(mport_q) < NUM_PORTS);
	assign hold_p = in_msg_q & mpv_q & (mport_q == in_q.port);
	assign wsat = (17'(in_q.weight) > 17'(MAX_WEIGHT)) ? 10'(MAX_WEIGHT) : in_q.weight;

	always_comb begin
		weight_d = weight_q;
		rv_d = rv_q;
		att_d = att_q;
		act_d = act_q;
		in_msg_d = in_msg_q;
		drop_d = drop_q;
		mpv_d = mpv_q;
		mport_d = mport_q;
		res_d = res_q;
		added = '0;
		sat_a = '0;
		if (ctl.exec) begin
			res_d = '{status: swps_pkg::ST_DONE, sel_port: 3'd0, hwm_blocked: 1'b0};
			case (in_q.cmd)
				swps_pkg::CMD_SEND: begin
					if (drop_q) begin
						in_msg_d = in_q.frame_more;
						drop_d = in_q.frame_more;
						res_d.status = swps_pkg::ST_DROPPED;
					end else if (mp_ok && (int'(mport_q) < swps_pkg::MASK_W)
							&& in_q.ready_mask[mport_q] && !in_q.too_large) begin
						in_msg_d = in_q.frame_more;
						if (!in_q.frame_more)
							mpv_d = 1'b0;
						res_d.status = swps_pkg::ST_SENT;
						res_d.sel_port = mport_q;
					end else begin
						drop_d = in_q.frame_more;
						in_msg_d = 1'b0;
						mpv_d = 1'b0;
						res_d.status = swps_pkg::ST_ABORTED;
					end
				end
				swps_pkg::CMD_ROLLBACK: begin
					in_msg_d = 1'b0;
					drop_d = 1'b0;
					mpv_d = 1'b0;
				end
				swps_pkg::CMD_ATTACH, swps_pkg::CMD_DETACH, swps_pkg::CMD_WEIGHT,
				swps_pkg::CMD_WRITABLE: begin
					for (int i = 0; i < NUM_PORTS; i++) begin
						if (port_ok && int'(in_q.port) == i) begin
							if (in_q.cmd == swps_pkg::CMD_ATTACH) begin
								if (!att_q[i]) begin
									att_d[i] = 1'b1;
									act_d[i] = 1'b1;
									weight_d[i] = 10'(DEFAULT_WEIGHT);
									rv_d[i] = '0;
								end
							end else if (att_q[i]) begin
								if (in_q.cmd == swps_pkg::CMD_DETACH) begin
									if (hold_p) begin
										drop_d = 1'b1;
										mpv_d = 1'b0;
									end
									att_d[i] = 1'b0;
									act_d[i] = 1'b0;
									weight_d[i] = '0;
									rv_d[i] = '0;
								end else if (in_q.cmd == swps_pkg::CMD_WEIGHT) begin
									if (wsat != weight_q[i]) begin
										weight_d[i] = wsat;
										if (wsat == '0) begin
											if (hold_p) begin
												drop_d = 1'b1;
												mpv_d = 1'b0;
											end
											act_d[i] = 1'b0;
										end else if (!act_q[i] && rdy[i]) begin
											act_d[i] = 1'b1;
										end
									end
								end else if (weight_q[i] != '0) begin
									act_d[i] = 1'b1;
								end
							end
						end
					end
				end
				default: ;
			endcase
		end else if (ctl.sel_step) begin
			res_d = '{status: swps_pkg::ST_DONE, sel_port: 3'd0, hwm_blocked: 1'b0};
			if (!found) begin
				res_d.status = positive ? swps_pkg::ST_AGAIN : swps_pkg::ST_REFUSED;
				res_d.hwm_blocked = hwm;
			end else if (in_q.too_large) begin
				res_d.status = swps_pkg::ST_TOO_LARGE;
			end else if (!best_rdy) begin
				for (int i = 0; i < NUM_PORTS; i++)
					if (3'(i) == best)
						act_d[i] = 1'b0;
			end else begin
				for (int i = 0; i < NUM_PORTS; i++) begin
					if (cand[i]) begin
						added = $signed({{(AW-RW){rv_q[i][RW-1]}}, rv_q[i]})
							+ $signed(AW'(weight_q[i]));
						sat_a = swps_pkg::sat16(added);
						added = $signed({{(AW-RW){sat_a[RW-1]}}, sat_a});
						if (3'(i) == best)
							added = added - $signed(total);
						rv_d[i] = swps_pkg::sat16(added);
					end
				end
				in_msg_d = in_q.frame_more;
				mport_d = best;
				mpv_d = in_q.frame_more;
				res_d.status = swps_pkg::ST_SENT;
				res_d.sel_port = best;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load)
			in_q <= item;
		res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PORTS; i++) begin
				weight_q[i] <= '0;
				rv_q[i] <= '0;
			end
			att_q <= '0;
			act_q <= '0;
			in_msg_q <= 1'b0;
			drop_q <= 1'b0;
			mpv_q <= 1'b0;
			mport_q <= '0;
		end else begin
			weight_q <= weight_d;
			rv_q <= rv_d;
			att_q <= att_d;
			act_q <= act_d;
			in_msg_q <= in_msg_d;
			drop_q <= drop_d;
			mpv_q <= mpv_d;
			mport_q <= mport_d;
		end
	end

	assign result = res_q;

endmodule

// ===== rtl/smooth_weighted_port_selector.sv =====
// top level: smooth weighted round-robin port selector
//
// A command beat is taken at a clock edge with start high and busy low.
// Commands attach, detach, reweight or re-enable a port, roll back message
// state, or send one frame. Each command yields exactly one result beat:
// done is high for one cycle with status, sel_port and hwm_blocked on result.
// The receiver cannot stall; the result is valid only during that cycle.
// Commands, and frames of a message already in progress or being dropped,
// pass from S_DECODE straight to S_RESULT; a first frame passes through
// S_SELECT in between, one pass of the NUM_PORTS-way max search per cycle, and
// repeats the pass for each chosen port found not ready and deactivated.
// busy stays high from the accepting edge through the result cycle, so one
// command runs at a time.
// Reset clears all weights, running values, attach and active flags and the
// message state; no result is pending after reset.
module smooth_weighted_port_selector #(
	parameter int NUM_PORTS      = 8,
	parameter int MAX_WEIGHT     = 1023,
	parameter int DEFAULT_WEIGHT = 100
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  swps_pkg::in_t   item,
	output logic            busy,
	output logic            done,
	output swps_pkg::out_t  result
);

	swps_pkg::ctl_t  ctl;
	swps_pkg::stat_t stat;

	swps_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	swps_dp #(
		.NUM_PORTS      (NUM_PORTS),
		.MAX_WEIGHT     (MAX_WEIGHT),
		.DEFAULT_WEIGHT (DEFAULT_WEIGHT)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.ctl    (ctl),
		.stat   (stat),
		.result (result)
	);

	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done) else $error("accepted beat not in work");

	a_hwm_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.hwm_blocked |->
			(result.status == swps_pkg::ST_AGAIN || result.status == swps_pkg::ST_REFUSED))
		else $error("hwm flag with wrong status");

endmodule

// ===== dv/smooth_weighted_port_selector_test.sv =====
// testbench: smooth weighted port selector, command beats checked against a software predictor
module smooth_weighted_port_selector_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NP = 8;
	localparam int MAXW = 1023;
	localparam int DEFW = 100;
	localparam int IDLE_LIMIT = 2000;
	localparam int IN_W = $bits(swps_pkg::in_t);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	swps_pkg::in_t item = '0;
	logic busy;
	logic done;
	swps_pkg::out_t result;

	smooth_weighted_port_selector #(.NUM_PORTS(NP), .MAX_WEIGHT(MAXW),
		.DEFAULT_WEIGHT(DEFW)) uut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item),
		.busy(busy), .done(done), .result(result));

	always #1 clk = ~clk;

	// predictor state
	int unsigned wt [NP];
	int rv [NP];
	bit att [NP];
	bit act [NP];
	bit in_msg, drop_md, mp_valid;
	int unsigned mp;

	swps_pkg::in_t pending_beats [$];
	swps_pkg::out_t expected_results [$];
	int errors = 0;
	int send_gap = 0;
	bit hold_send = 0;
	int idle_cycles = 0;

	function automatic int sat_rv(int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	function automatic swps_pkg::out_t mk(logic [2:0] st, int sel, bit h);
		swps_pkg::out_t o;
		o.status = st;
		o.sel_port = sel[2:0];
		o.hwm_blocked = h;
		return o;
	endfunction

	function automatic void drop_holder(int p);
		if (in_msg && mp_valid && mp == p) begin
			drop_md = 1;
			mp_valid = 0;
		end
	endfunction

	function automatic swps_pkg::out_t route_frame(swps_pkg::in_t b);
		int best, bv, tot, v;
		bit pos, hwm;
		if (drop_md) begin
			in_msg = b.frame_more;
			drop_md = b.frame_more;
			return mk(swps_pkg::ST_DROPPED, 0, 0);
		end
		if (in_msg && mp_valid) begin
			if (b.ready_mask[mp] && !b.too_large) begin
				in_msg = b.frame_more;
				if (!b.frame_more) mp_valid = 0;
				return mk(swps_pkg::ST_SENT, mp, 0);
			end
			drop_md = b.frame_more;
			in_msg = 0;
			mp_valid = 0;
			return mk(swps_pkg::ST_ABORTED, 0, 0);
		end
		forever begin
			best = -1;
			bv = 0;
			tot = 0;
			for (int i = 0; i < NP; i++)
				if (att[i] && act[i] && wt[i] > 0) begin
					v = rv[i] + int'(wt[i]);
					tot += wt[i];
					if (best < 0 || v > bv) begin
						best = i;
						bv = v;
					end
				end
			if (best < 0) break;
			if (b.too_large) return mk(swps_pkg::ST_TOO_LARGE, 0, 0);
			if (!b.ready_mask[best]) begin
				act[best] = 0;
				continue;
			end
			for (int i = 0; i < NP; i++)
				if (att[i] && act[i] && wt[i] > 0) rv[i] = sat_rv(rv[i] + int'(wt[i]));
			rv[best] = sat_rv(rv[best] - tot);
			in_msg = b.frame_more;
			mp = best;
			mp_valid = b.frame_more;
			return mk(swps_pkg::ST_SENT, best, 0);
		end
		pos = 0;
		hwm = 0;
		for (int i = 0; i < NP; i++)
			if (att[i] && wt[i] > 0) begin
				pos = 1;
				if (b.full_mask[i]) hwm = 1;
			end
		return mk(pos ? swps_pkg::ST_AGAIN : swps_pkg::ST_REFUSED, 0, hwm);
	endfunction

	function automatic swps_pkg::out_t predict_beat(swps_pkg::in_t b);
		int p;
		int unsigned w;
		p = b.port;
		w = b.weight;
		if (b.cmd == swps_pkg::CMD_SEND) return route_frame(b);
		if (b.cmd == swps_pkg::CMD_ROLLBACK) begin
			in_msg = 0;
			drop_md = 0;
			mp_valid = 0;
		end else if (b.cmd == swps_pkg::CMD_ATTACH) begin
			if (!att[p]) begin
				att[p] = 1;
				wt[p] = DEFW;
				rv[p] = 0;
				act[p] = 1;
			end
		end else if (b.cmd <= swps_pkg::CMD_ROLLBACK && att[p]) begin
			if (b.cmd == swps_pkg::CMD_DETACH) begin
				drop_holder(p);
				att[p] = 0;
				act[p] = 0;
				wt[p] = 0;
				rv[p] = 0;
			end else if (b.cmd == swps_pkg::CMD_WEIGHT) begin
				if (w > MAXW) w = MAXW;
				if (w != wt[p]) begin
					wt[p] = w;
					if (w == 0) begin
						drop_holder(p);
						act[p] = 0;
					end else if (!act[p] && b.ready_mask[p]) act[p] = 1;
				end
			end else if (b.cmd == swps_pkg::CMD_WRITABLE) begin
				if (wt[p] != 0) act[p] = 1;
			end
		end
		return mk(swps_pkg::ST_DONE, 0, 0);
	endfunction

	function automatic swps_pkg::in_t rand_beat(int mode);
		swps_pkg::in_t b;
		int r;
		b = swps_pkg::in_t'(IN_W'({$urandom, $urandom}));
		r = $urandom_range(99);
		if (mode == 1) begin
			// mostly frames with ports mostly ready
			if (r < 60) b.cmd = swps_pkg::CMD_SEND;
			else if (r < 70) b.cmd = swps_pkg::CMD_ATTACH;
			else if (r < 76) b.cmd = swps_pkg::CMD_DETACH;
			else if (r < 86) b.cmd = swps_pkg::CMD_WEIGHT;
			else if (r < 94) b.cmd = swps_pkg::CMD_WRITABLE;
			else if (r < 97) b.cmd = swps_pkg::CMD_ROLLBACK;
			if ($urandom_range(3) != 0) b.ready_mask = b.ready_mask | 8'(~($urandom & $urandom));
			if ($urandom_range(7) != 0) b.too_large = 0;
			if ($urandom_range(3) == 0) b.weight = 10'($urandom_range(20));
		end
		return b;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.insert(expected_results.size(), predict_beat(item));
				if (pending_beats.size() > 0 && !hold_send) begin
					item <= pending_beats.pop_front();
				end else start <= 1'b0;
			end else if (!start && pending_beats.size() > 0 && !hold_send &&
				($urandom_range(99) >= send_gap)) begin
				item <= pending_beats.pop_front();
				start <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		swps_pkg::out_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: status %0d", result.status);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (result.status !== e.status) begin
					$error("status expected %0d actual %0d", e.status, result.status);
					errors++;
				end
				if (result.sel_port !== e.sel_port) begin
					$error("sel_port expected %0d actual %0d", e.sel_port, result.sel_port);
					errors++;
				end
				if (result.hwm_blocked !== e.hwm_blocked) begin
					$error("hwm_blocked expected %0d actual %0d", e.hwm_blocked,
						result.hwm_blocked);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** smooth_weighted_port_selector: FAILED **");
			$finish;
		end
	end

	task automatic push(logic [2:0] c, int p, int w, bit more, int rdy, int full, bit big);
		swps_pkg::in_t b;
		b.cmd = c;
		b.port = p[2:0];
		b.weight = w[9:0];
		b.frame_more = more;
		b.ready_mask = rdy[7:0];
		b.full_mask = full[7:0];
		b.too_large = big;
		pending_beats.insert(pending_beats.size(), b);
	endtask

	task automatic drain();
		while (pending_beats.size() > 0 || start || busy || expected_results.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < NP; i++) begin
			wt[i] = 0; rv[i] = 0; att[i] = 0; act[i] = 0;
		end
		in_msg = 0; drop_md = 0; mp_valid = 0; mp = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: empty pool, attach, weights, frames, multipart, failures
		push(swps_pkg::CMD_SEND, 0, 0, 0, 8'hff, 8'hff, 0);
		push(swps_pkg::CMD_ATTACH, 0, 0, 0, 0, 0, 0);
		push(swps_pkg::CMD_ATTACH, 0, 0, 0, 0, 0, 0);
		push(swps_pkg::CMD_ATTACH, 7, 0, 0, 0, 0, 0);
		push(swps_pkg::CMD_WEIGHT, 7, 1023, 0, 8'hff, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 0, 8'hff, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 0, 8'hff, 0, 1);
		push(swps_pkg::CMD_SEND, 0, 0, 1, 8'hff, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 1, 8'hff, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 0, 8'hff, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 1, 8'hff, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 1, 8'h00, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 0, 8'hff, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 0, 8'h7f, 8'h80, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 0, 8'h00, 8'h81, 0);
		push(swps_pkg::CMD_WRITABLE, 0, 0, 0, 0, 0, 0);
		push(swps_pkg::CMD_WRITABLE, 3, 0, 0, 0, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 1, 8'hff, 0, 0);
		push(swps_pkg::CMD_DETACH, 7, 0, 0, 0, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 0, 8'hff, 0, 0);
		push(swps_pkg::CMD_WEIGHT, 0, 0, 0, 8'hff, 0, 0);
		push(swps_pkg::CMD_SEND, 0, 0, 0, 8'hff, 8'h01, 0);
		push(swps_pkg::CMD_WEIGHT, 0, 1, 0, 8'hff, 0, 0);
		push(swps_pkg::CMD_ROLLBACK, 0, 0, 0, 0, 0, 0);
		push(3'd6, 0, 0, 0, 0, 0, 0);
		push(3'd7, 0, 0, 0, 0, 0, 0);
		drain();
		// random phases, each with a pause with nothing expected part-way through
		for (int ph = 0; ph < 4; ph++) begin
			send_gap = (ph == 1) ? 61 : (ph == 3 ? 12 : 0);
			for (int n = 0; n < 400; n++) begin
				pending_beats.insert(pending_beats.size(),
					rand_beat($urandom_range(9) != 0));
				if (n == 200) begin
					drain();
					hold_send = 1;
					repeat (5) @(posedge clk);
					hold_send = 0;
				end
			end
			drain();
		end
		repeat (20) @(posedge clk);
		if (errors == 0) $display("** smooth_weighted_port_selector: PASSED **");
		else $display("** smooth_weighted_port_selector: FAILED **");
		$finish;
	end
endmodule
